>>> src/nbs_pkg.sv
package nbs_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PAREN = 2'd0;
    localparam kind_t KIND_BRACE = 2'd1;
    localparam kind_t KIND_SQUARE = 2'd2;
    localparam kind_t KIND_ANGLE = 2'd3;

    localparam logic [7:0] CHR_PAREN_OPEN   = 8'h28;
    localparam logic [7:0] CHR_PAREN_CLOSE  = 8'h29;
    localparam logic [7:0] CHR_BRACE_OPEN   = 8'h7B;
    localparam logic [7:0] CHR_BRACE_CLOSE  = 8'h7D;
    localparam logic [7:0] CHR_SQUARE_OPEN  = 8'h5B;
    localparam logic [7:0] CHR_SQUARE_CLOSE = 8'h5D;
    localparam logic [7:0] CHR_ANGLE_OPEN   = 8'h3C;
    localparam logic [7:0] CHR_ANGLE_CLOSE  = 8'h3E;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       opener;
        logic       closer;
        kind_t      kind;
    } item_t;

endpackage

>>> src/nbs_in_if.sv
interface nbs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_start;

    modport source (output valid, output in_byte, output string_start, input ready);
    modport sink (input valid, input in_byte, input string_start, output ready);
endinterface

>>> src/nbs_out_if.sv
interface nbs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink (input valid, input out_byte, output ready);
endinterface

>>> src/nested_bracket_stripper.sv
// bracket stripping filter for a byte stream
// in_chan carries one text byte per request with string_start marking the
// first byte of a new string; out_chan carries each byte that lies outside
// every bracket group, in order, and nothing for discarded bytes
// openers ( { [ < are stacked up to 32 deep; a closer pops only when it
// matches the kind on top; openers beyond the full stack are dropped
// front stage classifies each byte, a four-entry queue decouples it from the
// back end, which owns the kind stack and the output register
// a kept byte passes the front stage register, the queue and the output
// register before it is offered on out_chan
// throughput: one request per cycle unless out_chan stalls, set by the stack update
// reset empties the stack, the queue and the output register
// when the receiver stalls the output register holds its byte, the queue
// fills behind it and in_chan.ready drops once front stage and queue are full
module nested_bracket_stripper import nbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    nbs_in_if.sink     in_chan,
    nbs_out_if.source  out_chan
);

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    nbs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_chan    (in_chan),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    nbs_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    nbs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .out_chan   (out_chan)
    );

endmodule

>>> src/nbs_front.sv
module nbs_front import nbs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    nbs_in_if.sink in_chan,
    output logic  push_valid,
    input  logic  push_ready,
    output item_t push_item
);

    logic  stage_valid_reg;
    logic  stage_valid_next;
    item_t stage_item_reg;
    item_t stage_item_next;
    logic  accept;

    always_comb
    begin
        stage_item_next        = '0;
        stage_item_next.data   = in_chan.in_byte;
        stage_item_next.start  = in_chan.string_start;
        unique case (in_chan.in_byte)
            CHR_PAREN_OPEN:
            begin
                stage_item_next.opener = 1'b1;
                stage_item_next.kind   = KIND_PAREN;
            end
            CHR_BRACE_OPEN:
            begin
                stage_item_next.opener = 1'b1;
                stage_item_next.kind   = KIND_BRACE;
            end
            CHR_SQUARE_OPEN:
            begin
                stage_item_next.opener = 1'b1;
                stage_item_next.kind   = KIND_SQUARE;
            end
            CHR_ANGLE_OPEN:
            begin
                stage_item_next.opener = 1'b1;
                stage_item_next.kind   = KIND_ANGLE;
            end
            CHR_PAREN_CLOSE:
            begin
                stage_item_next.closer = 1'b1;
                stage_item_next.kind   = KIND_PAREN;
            end
            CHR_BRACE_CLOSE:
            begin
                stage_item_next.closer = 1'b1;
                stage_item_next.kind   = KIND_BRACE;
            end
            CHR_SQUARE_CLOSE:
            begin
                stage_item_next.closer = 1'b1;
                stage_item_next.kind   = KIND_SQUARE;
            end
            CHR_ANGLE_CLOSE:
            begin
                stage_item_next.closer = 1'b1;
                stage_item_next.kind   = KIND_ANGLE;
            end
            default:
            begin
                stage_item_next.kind = KIND_PAREN;
            end
        endcase
    end

    assign in_chan.ready = !stage_valid_reg || push_ready;
    assign accept        = in_chan.valid && in_chan.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg <= stage_item_next;
        end
    end

    assign push_valid = stage_valid_reg;
    assign push_item  = stage_item_reg;

endmodule

>>> src/nbs_queue.sv
module nbs_queue import nbs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> src/nbs_back.sv
module nbs_back import nbs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pop_valid,
    output logic   pop_ready,
    input  item_t  pop_item,
    nbs_out_if.source out_chan
);

    kind_t               stack_reg [STACK_DEPTH];
    logic [DEPTH_W-1:0]  depth_reg;
    logic [DEPTH_W-1:0]  depth_next;
    logic [DEPTH_W-1:0]  depth_eff;
    logic [IDX_W-1:0]    top_idx;
    kind_t               top_kind;
    logic                fire;
    logic                push;
    logic                emit;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [7:0]          out_byte_reg;

    assign pop_ready = !out_valid_reg || out_chan.ready;
    assign fire      = pop_valid && pop_ready;

    // a new string empties the stack before its byte is looked at
    assign depth_eff = pop_item.start ? '0 : depth_reg;
    assign top_idx   = IDX_W'(depth_reg - DEPTH_W'(1));
    assign top_kind  = stack_reg[top_idx];

    assign push = pop_item.opener && (depth_eff != DEPTH_W'(STACK_DEPTH));
    assign emit = (depth_eff == '0) && !pop_item.opener;

    always_comb
    begin
        depth_next = depth_reg;
        if (fire)
        begin
            depth_next = depth_eff;
            if (push)
            begin
                depth_next = depth_eff + DEPTH_W'(1);
            end
            else if (depth_eff != '0 && pop_item.closer && top_kind == pop_item.kind)
            begin
                depth_next = depth_eff - DEPTH_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && push)
        begin
            stack_reg[depth_eff[IDX_W-1:0]] <= pop_item.kind;
        end
        if (fire && emit)
        begin
            out_byte_reg <= pop_item.data;
        end
    end

    assign out_chan.valid    = out_valid_reg;
    assign out_chan.out_byte = out_byte_reg;

endmodule
